### rtl/mtmf_pkg.sv
// ----------------------------------------------------------------------------
// mtmf_pkg: shared types and constants
// Field widths, register indexes, queue entries and back-end states.
// ----------------------------------------------------------------------------
package mtmf_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 4 * CH_W;
    localparam int COORD_W    = 7;
    localparam int POS_W      = 6;
    localparam int KER_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int CNT_W      = 8;
    localparam int MIN_KERNEL = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_WIDTH  = 2'd0,
        CFG_TILE_HEIGHT = 2'd1,
        CFG_KERNEL_SIZE = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } op_t;

    typedef struct packed {
        logic [COORD_W-1:0] tile_width;
        logic [COORD_W-1:0] tile_height;
        logic [KER_W-1:0]   kernel_size;
    } cfg_t;

    // One classified request as it waits between front and back.
    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] w_eff;
        logic [COORD_W-1:0] h_eff;
        logic [KER_W-1:0]   kernel;
        logic               kernel_ok;
        logic [PIX_W-1:0]   pixel;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CENTER,
        B_SCAN,
        B_TAIL,
        B_OUT
    } back_state_t;

endpackage

### rtl/mtmf_in_if.sv
// ----------------------------------------------------------------------------
// mtmf_in_if: input request channel
// Valid/ready channel carrying one load or fetch request.
// ----------------------------------------------------------------------------
interface mtmf_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [5:0] column;
    logic [5:0] line;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;

    modport source (output valid, operation, column, line, red_in, green_in, blue_in,
                    alpha_in, input ready);
    modport sink (input valid, operation, column, line, red_in, green_in, blue_in,
                  alpha_in, output ready);
endinterface

### rtl/mtmf_out_if.sv
// ----------------------------------------------------------------------------
// mtmf_out_if: result channel
// Valid/ready channel carrying one fetched pixel.
// ----------------------------------------------------------------------------
interface mtmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       was_crack;
    logic       status;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, was_crack,
                    status, input ready);
    modport sink (input valid, red_out, green_out, blue_out, alpha_out, was_crack,
                  status, output ready);
endinterface

### rtl/mtmf_cfg_if.sv
// ----------------------------------------------------------------------------
// mtmf_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mtmf_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/mtmf_ram.sv
// ----------------------------------------------------------------------------
// mtmf_ram: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mtmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule

### rtl/mtmf_front.sv
// ----------------------------------------------------------------------------
// mtmf_front: request front end
// Classifies requests, clamps fetch coordinates and queues them for the back.
// ----------------------------------------------------------------------------
module mtmf_front
    import mtmf_pkg::*;
#(
    parameter int MAX_TILE   = 64,
    parameter int MAX_KERNEL = 7
) (
    input  logic         clk,
    input  logic         rst_n,
    mtmf_in_if.sink      in_ch,
    input  cfg_t         cfg,
    output job_t         job,
    output logic         job_valid,
    input  logic         job_pop
);
    job_t       queue_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    logic [COORD_W-1:0] w_eff, h_eff, col_ext, row_ext;
    logic               kernel_ok, accept, in_tile, push;
    job_t               entry;

    // Effective tile size, limited to between one and the maximum.
    always_comb
    begin
        if (cfg.tile_width == '0)
            w_eff = COORD_W'(1);
        else if (int'(cfg.tile_width) > MAX_TILE)
            w_eff = COORD_W'(MAX_TILE);
        else
            w_eff = cfg.tile_width;
        if (cfg.tile_height == '0)
            h_eff = COORD_W'(1);
        else if (int'(cfg.tile_height) > MAX_TILE)
            h_eff = COORD_W'(MAX_TILE);
        else
            h_eff = cfg.tile_height;
    end

    assign kernel_ok = (cfg.kernel_size >= KER_W'(MIN_KERNEL)) && cfg.kernel_size[0]
                       && (int'(cfg.kernel_size) <= MAX_KERNEL);

    // Classify: loads outside the tile are dropped, fetches are clamped.
    always_comb
    begin
        col_ext         = {1'b0, in_ch.column};
        row_ext         = {1'b0, in_ch.line};
        in_tile         = (col_ext < w_eff) && (row_ext < h_eff);
        entry.op        = op_t'(in_ch.operation);
        entry.col       = (col_ext >= w_eff) ? w_eff - COORD_W'(1) : col_ext;
        entry.row       = (row_ext >= h_eff) ? h_eff - COORD_W'(1) : row_ext;
        entry.w_eff     = w_eff;
        entry.h_eff     = h_eff;
        entry.kernel    = cfg.kernel_size;
        entry.kernel_ok = kernel_ok;
        entry.pixel     = {in_ch.alpha_in, in_ch.blue_in, in_ch.green_in, in_ch.red_in};
    end

    assign in_ch.ready = (count_reg != 2'd2);
    assign accept      = in_ch.valid && in_ch.ready;
    assign push        = accept && ((entry.op == OP_FETCH) || in_tile);
    assign job_valid   = (count_reg != 2'd0);
    assign job         = queue_reg[rd_ptr_reg];

    // Queue pointer and fill updates.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = job_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, job_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end
endmodule

### rtl/mtmf_back.sv
// ----------------------------------------------------------------------------
// mtmf_back: request back end
// Owns the tile RAM; runs loads, fetches and the bit-serial window median.
// ----------------------------------------------------------------------------
module mtmf_back
    import mtmf_pkg::*;
#(
    parameter int MAX_TILE = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        job,
    input  logic        job_valid,
    output logic        job_pop,
    mtmf_out_if.source  out_ch
);
    localparam int DEPTH = MAX_TILE * MAX_TILE;
    localparam int ADW   = $clog2(DEPTH);
    localparam int SW    = COORD_W + 2;

    back_state_t state_reg, state_next;

    logic [COORD_W-1:0] cx_reg, cy_reg, w_reg, h_reg;
    logic [KER_W-1:0]   k_reg, dx_reg, dy_reg;
    logic               kok_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [2:0]         bit_reg, bit_d_reg;
    logic               rv_d_reg, last_d_reg;
    logic [CH_W-1:0]    prefix_reg [4];
    logic [CNT_W-1:0]   lo_reg [4];
    logic [CNT_W-1:0]   cnt_reg [4];

    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_pix_reg;
    logic               out_crack_reg, out_status_reg;

    logic               wr_en, rd_en, last_issue, pass_end, out_free, crack;
    logic [ADW-1:0]     wr_addr, rd_addr;
    logic [PIX_W-1:0]   rd_data;
    logic [KER_W-1:0]   radius;
    logic [CNT_W-1:0]   mid;
    logic [COORD_W-1:0] wx, wy;
    logic signed [SW-1:0] sx, sy;

    mtmf_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_tile (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (job.pixel),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign radius     = k_reg >> 1;
    assign mid        = CNT_W'((CNT_W'(k_reg) * CNT_W'(k_reg)) >> 1);
    assign pass_end   = (dx_reg == k_reg - KER_W'(1)) && (dy_reg == k_reg - KER_W'(1));
    assign last_issue = pass_end && (bit_reg == 3'd0);
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign crack      = kok_reg && (pix_reg[PIX_W-1 -: CH_W] == '0);

    // Window coordinates clamped to the tile.
    always_comb
    begin
        sx = $signed({2'b00, cx_reg}) + $signed(SW'(dx_reg)) - $signed(SW'(radius));
        sy = $signed({2'b00, cy_reg}) + $signed(SW'(dy_reg)) - $signed(SW'(radius));
        if (sx < 0)
            wx = '0;
        else if (sx >= $signed({2'b00, w_reg}))
            wx = w_reg - COORD_W'(1);
        else
            wx = sx[COORD_W-1:0];
        if (sy < 0)
            wy = '0;
        else if (sy >= $signed({2'b00, h_reg}))
            wy = h_reg - COORD_W'(1);
        else
            wy = sy[COORD_W-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (job_valid && (job.op == OP_FETCH))
                    state_next = B_CENTER;
            B_CENTER:
                if (kok_reg && (rd_data[PIX_W-1 -: CH_W] == '0))
                    state_next = B_SCAN;
                else
                    state_next = B_OUT;
            B_SCAN:
                if (last_issue)
                    state_next = B_TAIL;
            B_TAIL:
                state_next = B_OUT;
            B_OUT:
                if (out_free)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    // Memory controls and queue pop.
    always_comb
    begin
        job_pop = 1'b0;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        wr_addr = ADW'(job.row) * ADW'(MAX_TILE) + ADW'(job.col);
        rd_addr = ADW'(wy) * ADW'(MAX_TILE) + ADW'(wx);
        case (state_reg)
            B_IDLE:
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    if (job.op == OP_LOAD)
                        wr_en = 1'b1;
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = wr_addr;
                    end
                end
            B_SCAN:
                rd_en = 1'b1;
            default:
                rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rv_d_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_d_reg  <= (state_reg == B_SCAN);
            if ((state_reg == B_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath: request latch, window walk and radix select per channel.
    always_ff @(posedge clk)
    begin
        logic             match;
        logic [CNT_W-1:0] total;
        logic [CH_W-1:0]  mask;
        if ((state_reg == B_IDLE) && job_valid)
        begin
            cx_reg  <= job.col;
            cy_reg  <= job.row;
            w_reg   <= job.w_eff;
            h_reg   <= job.h_eff;
            k_reg   <= job.kernel;
            kok_reg <= job.kernel_ok;
        end
        if (state_reg == B_CENTER)
        begin
            pix_reg <= rd_data;
            bit_reg <= 3'd7;
            dx_reg  <= '0;
            dy_reg  <= '0;
            for (int c = 0; c < 4; c++)
            begin
                prefix_reg[c] <= '0;
                lo_reg[c]     <= '0;
                cnt_reg[c]    <= '0;
            end
        end
        if (state_reg == B_SCAN)
        begin
            if (dx_reg == k_reg - KER_W'(1))
            begin
                dx_reg <= '0;
                if (dy_reg == k_reg - KER_W'(1))
                begin
                    dy_reg  <= '0;
                    bit_reg <= bit_reg - 3'd1;
                end
                else
                    dy_reg <= dy_reg + KER_W'(1);
            end
            else
                dx_reg <= dx_reg + KER_W'(1);
        end
        bit_d_reg  <= bit_reg;
        last_d_reg <= pass_end;
        // Count samples that share the decided prefix with a zero at the
        // current bit; at the end of a pass decide that bit.
        if (rv_d_reg)
        begin
            mask = CH_W'(8'hFF << bit_d_reg);
            for (int c = 0; c < 4; c++)
            begin
                match = ((rd_data[c*CH_W +: CH_W] & mask) == prefix_reg[c]);
                total = cnt_reg[c] + CNT_W'(match);
                if (last_d_reg)
                begin
                    cnt_reg[c] <= '0;
                    if (lo_reg[c] + total <= mid)
                    begin
                        prefix_reg[c] <= prefix_reg[c] | CH_W'(8'h01 << bit_d_reg);
                        lo_reg[c]     <= lo_reg[c] + total;
                    end
                end
                else
                    cnt_reg[c] <= total;
            end
        end
        // Result register.
        if ((state_reg == B_OUT) && out_free)
        begin
            out_crack_reg  <= crack;
            out_status_reg <= !kok_reg;
            if (crack)
                out_pix_reg <= {prefix_reg[3], prefix_reg[2], prefix_reg[1], prefix_reg[0]};
            else
                out_pix_reg <= pix_reg;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.red_out   = out_pix_reg[0*CH_W +: CH_W];
    assign out_ch.green_out = out_pix_reg[1*CH_W +: CH_W];
    assign out_ch.blue_out  = out_pix_reg[2*CH_W +: CH_W];
    assign out_ch.alpha_out = out_pix_reg[3*CH_W +: CH_W];
    assign out_ch.was_crack = out_crack_reg;
    assign out_ch.status    = out_status_reg;
endmodule

### rtl/masked_tile_median_fill.sv
// ----------------------------------------------------------------------------
// masked_tile_median_fill: crack inpainting by masked median filtering
// Holds one pixel tile; fetches replace cracked pixels by a window median.
// ----------------------------------------------------------------------------
// Channel   Role   Carries
// in_ch     sink   operation, column, line, red_in .. alpha_in
// out_ch    source red_out .. alpha_out, was_crack, status
// cfg       sink   index, data (tile_width, tile_height, kernel_size)
//
// A load is written to the tile RAM from the back end's idle state; a plain fetch
// reads the centre pixel and goes on to the result register. A crack fetch walks
// the window once per result bit through the single tile RAM read port.
// Reset clears the control state and restores the register defaults; the
// tile RAM holds no defined data until written. A two-entry queue keeps
// requests flowing in while the back end or the result register stalls.
// ----------------------------------------------------------------------------
module masked_tile_median_fill
    import mtmf_pkg::*;
#(
    parameter int MAX_TILE   = 64,
    parameter int MAX_KERNEL = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    mtmf_in_if.sink     in_ch,
    mtmf_out_if.source  out_ch,
    mtmf_cfg_if.sink    cfg
);
    cfg_t cfg_reg;
    job_t job;
    logic job_valid, job_pop;

    assign cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tile_width  <= COORD_W'(64);
            cfg_reg.tile_height <= COORD_W'(64);
            cfg_reg.kernel_size <= KER_W'(3);
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_TILE_WIDTH:  cfg_reg.tile_width  <= cfg.data;
                CFG_TILE_HEIGHT: cfg_reg.tile_height <= cfg.data;
                CFG_KERNEL_SIZE: cfg_reg.kernel_size <= cfg.data[KER_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    mtmf_front #(.MAX_TILE(MAX_TILE), .MAX_KERNEL(MAX_KERNEL)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg_reg),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop)
    );

    mtmf_back #(.MAX_TILE(MAX_TILE)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .out_ch    (out_ch)
    );
endmodule

### bench/masked_tile_median_fill_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_tile_median_fill_test: self-checking bench for the crack filler
// Loads tiles, fetches pixels under several tile and kernel settings
// and compares each fetched pixel with its stored value or, for a crack, a window median.
// ----------------------------------------------------------------------------
module masked_tile_median_fill_test
    import mtmf_pkg::*;
();

    localparam int TILE_SIDE   = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 20;

    // Tile mirror, register copy and the queue of pixels still owed by the block.
    class tile_fill_scoreboard;
        typedef struct {
            bit [7:0] red;
            bit [7:0] green;
            bit [7:0] blue;
            bit [7:0] alpha;
            bit       crack;
            bit       status;
        } fetched_pixel_t;

        bit [31:0]      tile_mirror [TILE_SIDE*TILE_SIDE];
        bit             written [TILE_SIDE*TILE_SIDE];
        int             width_reg;
        int             height_reg;
        int             kernel_reg;
        fetched_pixel_t owed_pixels [$];
        int             errors;

        function new();
            width_reg  = 64;
            height_reg = 64;
            kernel_reg = 3;
            errors     = 0;
        endfunction

        function void write_reg(cfg_index_t idx, int value);
            case (idx)
                CFG_TILE_WIDTH:  width_reg  = value & 8'h7F;
                CFG_TILE_HEIGHT: height_reg = value & 8'h7F;
                CFG_KERNEL_SIZE: kernel_reg = value & 8'h07;
                default: ;
            endcase
        endfunction

        function int eff_dim(int v);
            return (v < 1) ? 1 : (v > TILE_SIDE) ? TILE_SIDE : v;
        endfunction

        function int tile_w();
            return eff_dim(width_reg);
        endfunction

        function int tile_h();
            return eff_dim(height_reg);
        endfunction

        function int clamp(int v, int limit);
            return (v < 0) ? 0 : (v >= limit) ? limit - 1 : v;
        endfunction

        // Median of one channel over the window, border replicated.
        function bit [7:0] window_median(int cx, int cy, int shift);
            int vals [$];
            int half;
            int x;
            int y;
            half = kernel_reg / 2;
            for (int dy = -half; dy <= half; dy++)
            begin
                y = clamp(cy + dy, tile_h());
                for (int dx = -half; dx <= half; dx++)
                begin
                    x = clamp(cx + dx, tile_w());
                    vals.insert(vals.size(), (tile_mirror[y*TILE_SIDE + x] >> shift) & 8'hFF);
                end
            end
            vals.sort();
            return vals[vals.size() / 2];
        endfunction

        // Record one accepted request; a fetch adds the pixel it must return.
        function void note_request(op_t op, int col, int row, bit [31:0] pix);
            fetched_pixel_t res;
            bit [31:0]      stored;
            bit             kernel_ok;
            if (op == OP_LOAD)
            begin
                if (col < tile_w() && row < tile_h())
                begin
                    tile_mirror[row*TILE_SIDE + col] = pix;
                    written[row*TILE_SIDE + col]     = 1'b1;
                end
                return;
            end
            col       = clamp(col, tile_w());
            row       = clamp(row, tile_h());
            stored    = tile_mirror[row*TILE_SIDE + col];
            kernel_ok = kernel_reg >= MIN_KERNEL && kernel_reg[0];
            res.red    = stored[7:0];
            res.green  = stored[15:8];
            res.blue   = stored[23:16];
            res.alpha  = stored[31:24];
            res.crack  = 1'b0;
            res.status = !kernel_ok;
            if (kernel_ok && stored[31:24] == 8'd0)
            begin
                res.red   = window_median(col, row, 0);
                res.green = window_median(col, row, 8);
                res.blue  = window_median(col, row, 16);
                res.alpha = window_median(col, row, 24);
                res.crack = 1'b1;
            end
            owed_pixels.insert(owed_pixels.size(), res);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one returned pixel with the oldest owed one.
        function void check_result(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [7:0] a,
                                   bit crack, bit status);
            fetched_pixel_t want;
            if (owed_pixels.size() == 0)
            begin
                $error("result with no fetch outstanding");
                errors++;
                return;
            end
            want = owed_pixels.pop_front();
            compare_field("red_out", want.red, r);
            compare_field("green_out", want.green, g);
            compare_field("blue_out", want.blue, b);
            compare_field("alpha_out", want.alpha, a);
            compare_field("was_crack", want.crack, crack);
            compare_field("status", want.status, status);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   idle_mode;

    mtmf_in_if  in_ch ();
    mtmf_out_if out_ch ();
    mtmf_cfg_if cfg ();

    tile_fill_scoreboard pixel_board;

    masked_tile_median_fill u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // Clock and run limit.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("masked_tile_median_fill_test: done, errors");
            $finish;
        end
    end

    // Result side: random stalls by phase, check every accepted result.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            pixel_board.check_result(out_ch.red_out, out_ch.green_out, out_ch.blue_out,
                                     out_ch.alpha_out, out_ch.was_crack, out_ch.status);
        case (idle_mode)
            2:       out_ch.ready <= $urandom_range(99) >= 72;
            3:       out_ch.ready <= $urandom_range(99) >= 26;
            default: out_ch.ready <= 1'b1;
        endcase
    end

    // Send one request, with a random gap before it in the idling phases.
    task automatic send_request(op_t op, int col, int row, bit [31:0] pix);
        while ((idle_mode == 1 && $urandom_range(99) < 72) ||
               (idle_mode == 3 && $urandom_range(99) < 26))
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.column    <= col[5:0];
        in_ch.line      <= row[5:0];
        in_ch.red_in    <= pix[7:0];
        in_ch.green_in  <= pix[15:8];
        in_ch.blue_in   <= pix[23:16];
        in_ch.alpha_in  <= pix[31:24];
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pixel_board.note_request(op, col, row, pix);
    endtask

    // Write one register once the block has drained.
    task automatic write_reg(cfg_index_t idx, int value);
        in_ch.valid <= 1'b0;
        while (pixel_board.owed_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value[6:0];
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        pixel_board.write_reg(idx, value);
    endtask

    // Random pixel; about a third are cracks.
    function automatic bit [31:0] random_pixel();
        bit [31:0] pix;
        pix = $urandom();
        if ($urandom_range(2) == 0)
            pix[31:24] = 8'd0;
        return pix;
    endfunction

    // Load every pixel of the current tile that has not been written yet.
    task automatic fill_tile();
        for (int row = 0; row < pixel_board.tile_h(); row++)
            for (int col = 0; col < pixel_board.tile_w(); col++)
                if (!pixel_board.written[row*TILE_SIDE + col])
                    send_request(OP_LOAD, col, row, random_pixel());
    endtask

    // Random mix of loads and fetches; ignored loads do not count.
    task automatic random_requests(int count);
        int   done;
        int   col;
        int   row;
        op_t  op;
        done = 0;
        while (done < count)
        begin
            op  = $urandom_range(1) ? OP_FETCH : OP_LOAD;
            col = $urandom_range(pixel_board.tile_w() - 1);
            row = $urandom_range(pixel_board.tile_h() - 1);
            if ($urandom_range(4) == 0)
            begin
                col = $urandom_range(63);
                row = $urandom_range(63);
            end
            send_request(op, col, row, random_pixel());
            if (op == OP_FETCH || (col < pixel_board.tile_w() && row < pixel_board.tile_h()))
                done++;
        end
    endtask

    task automatic set_tile(int w, int h, int k);
        write_reg(CFG_TILE_WIDTH, w);
        write_reg(CFG_TILE_HEIGHT, h);
        write_reg(CFG_KERNEL_SIZE, k | ($urandom_range(15) << 3));
    endtask

    initial
    begin
        int settings [10][3] = '{
            '{4, 4, 3}, '{0, 5, 5}, '{127, 1, 7}, '{3, 3, 7}, '{5, 6, 0},
            '{2, 64, 3}, '{6, 5, 4}, '{7, 7, 1}, '{1, 1, 6}, '{8, 8, 5}
        };
        pixel_board    = new();
        idle_mode      = 0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.operation = OP_LOAD;
        in_ch.column   = '0;
        in_ch.line     = '0;
        in_ch.red_in   = '0;
        in_ch.green_in = '0;
        in_ch.blue_in  = '0;
        in_ch.alpha_in = '0;
        cfg.valid      = 1'b0;
        cfg.index      = CFG_TILE_WIDTH;
        cfg.data       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 10; phase++)
        begin
            idle_mode = 0;
            set_tile(settings[phase][0], settings[phase][1], settings[phase][2]);
            idle_mode = phase % 4;
            fill_tile();
            if (phase == 0)
            begin
                // Extremes: black crack corner, white opaque corner, loads and
                // fetches far outside the tile.
                send_request(OP_LOAD, 0, 0, 32'h0000_0000);
                send_request(OP_LOAD, 3, 3, 32'hFFFF_FFFF);
                send_request(OP_LOAD, 63, 63, 32'h00FF_FFFF);
                send_request(OP_LOAD, 2, 40, 32'h0012_3456);
                send_request(OP_FETCH, 0, 0, 32'h0);
                send_request(OP_FETCH, 63, 63, 32'hFFFF_FFFF);
                send_request(OP_FETCH, 63, 0, 32'h0);
                send_request(OP_FETCH, 0, 63, 32'h0);
                send_request(OP_LOAD, 1, 1, 32'h0080_7F01);
                send_request(OP_FETCH, 1, 1, 32'h0);
                send_request(OP_FETCH, 2, 2, 32'h0);
            end
            random_requests(phase == 5 ? 40 : 55);
        end

        in_ch.valid <= 1'b0;
        while (pixel_board.owed_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (pixel_board.owed_pixels.size() == 0 && pixel_board.errors == 0)
            $display("masked_tile_median_fill_test: done, clean");
        else
            $display("masked_tile_median_fill_test: done, errors");
        $finish;
    end

endmodule

### files.f
rtl/mtmf_pkg.sv
rtl/mtmf_in_if.sv
rtl/mtmf_out_if.sv
rtl/mtmf_cfg_if.sv
rtl/mtmf_ram.sv
rtl/mtmf_front.sv
rtl/mtmf_back.sv
rtl/masked_tile_median_fill.sv
bench/masked_tile_median_fill_test.sv
